// File: rtl/assert_macros.svh
// Assertion macros shared by the list engine RTL.
// Standalone header; users take it by include. SYNTH strips the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition in one cycle implies a property in the next.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg)
`endif

`endif

// File: rtl/bole_pkg.sv
// Shared types and constants for the bounded ordered list engine.
// No dependencies; used by bole_cell and bounded_ordered_list_engine.
`timescale 1ns / 1ps
`default_nettype none

package bole_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Word field widths
    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Commands
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd5;

    // Result status
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // Cell operations
    localparam int CELL_OP_W = 3;
    localparam logic [CELL_OP_W-1:0] CELL_HOLD       = 3'd0;
    localparam logic [CELL_OP_W-1:0] CELL_LOAD       = 3'd1;
    localparam logic [CELL_OP_W-1:0] CELL_FROM_LEFT  = 3'd2;
    localparam logic [CELL_OP_W-1:0] CELL_FROM_RIGHT = 3'd3;
    localparam logic [CELL_OP_W-1:0] CELL_FROM_FRONT = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } req_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [VAL_W-1:0] elem_value;
        logic [COUNT_W-1:0]      count;
        logic                    last;
    } rsp_word_t;

    typedef struct packed {
        logic [CELL_OP_W-1:0] op;
        logic [VAL_W-1:0]     load_value;
    } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/bole_cell.sv
// One storage cell of the list chain: a value register fed from its neighbors, the front cell or a load.
// Depends on bole_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bole_cell (
    input  logic                         clk,
    input  bole_pkg::cell_ctl_t          ctl,
    input  logic [bole_pkg::VAL_W-1:0]   left_value,
    input  logic [bole_pkg::VAL_W-1:0]   right_value,
    input  logic [bole_pkg::VAL_W-1:0]   front_value,
    output logic [bole_pkg::VAL_W-1:0]   value
);

    logic [bole_pkg::VAL_W-1:0] value_reg;
    logic [bole_pkg::VAL_W-1:0] value_next;

    always_comb
    begin
        case (ctl.op)
            bole_pkg::CELL_HOLD:       value_next = value_reg;
            bole_pkg::CELL_LOAD:       value_next = ctl.load_value;
            bole_pkg::CELL_FROM_LEFT:  value_next = left_value;
            bole_pkg::CELL_FROM_RIGHT: value_next = right_value;
            bole_pkg::CELL_FROM_FRONT: value_next = front_value;
            default:                   value_next = value_reg;
        endcase
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// File: rtl/bounded_ordered_list_engine.sv
// Top level of the bounded ordered list engine: control plus the chain of cells.
// Depends on bole_pkg, bole_cell and assert_macros.svh.
//
// Usage:
//   req channel (req_valid / req_stall / req_word) carries one command word:
//   push front, push back, insert at a 1-based position, pop front, pop back
//   or dump. rsp channel (rsp_valid / rsp_stall / rsp_word) returns results.
//   Every update gives one result word (last = 1) in the cycle after accept;
//   updates sustain one word per cycle while rsp_stall is low. A dump of N
//   elements gives N words, front first, last set on the final one;
//   req_stall stays high until the final word is registered. An empty
//   dump answers with one word, status empty.
//   The chain rotates by one cell per dump word, so after N words the list
//   is back in its original order; one cell step per cycle, while rsp_stall is low, sets the rate.
//   Reset (rst_n low, async) empties the list and drops any pending result;
//   cell contents are not cleared and are never read before being written.
//   When rsp_stall is high against a valid result word, that word holds and
//   req_stall rises, so no new command is taken until the held word drains.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bounded_ordered_list_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  bole_pkg::req_word_t req_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output bole_pkg::rsp_word_t rsp_word
);

    localparam int CAP   = bole_pkg::CAPACITY;
    localparam int CNT_W = bole_pkg::CNT_W;

    // Control state
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                dump_reg, dump_next;
    logic [CNT_W-1:0]    dump_left_reg, dump_left_next;
    logic                rsp_valid_reg, rsp_valid_next;
    bole_pkg::rsp_word_t rsp_word_reg, rsp_word_next;

    // Decode
    logic                slot_free;
    logic                req_accept;
    logic                dump_adv;
    logic                full;
    logic                empty;
    logic [CNT_W:0]      pos_ext;
    logic [CNT_W:0]      cnt_p1;
    logic                pos_ok;
    logic                do_insert;
    logic                do_pop_front;
    logic                start_dump;
    logic [CNT_W-1:0]    ins_idx;
    logic [CNT_W-1:0]    upd_count;
    logic [bole_pkg::STATUS_W-1:0] upd_status;

    // Chain
    logic [bole_pkg::VAL_W-1:0] cell_value [CAP];

    // Output slot frees when empty or being taken this cycle.
    assign slot_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall  = dump_reg || !slot_free;
    assign req_accept = req_valid && !req_stall;
    assign dump_adv   = dump_reg && slot_free;

    assign full    = (count_reg == CNT_W'(CAP));
    assign empty   = (count_reg == '0);
    assign pos_ext = (CNT_W + 1)'(req_word.position);
    assign cnt_p1  = {1'b0, count_reg} + 1'b1;
    assign pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_p1);

    // Command decode; status check order follows the spec: position, then full.
    always_comb
    begin
        do_insert    = 1'b0;
        do_pop_front = 1'b0;
        start_dump   = 1'b0;
        ins_idx      = '0;
        upd_count    = count_reg;
        upd_status   = bole_pkg::ST_OK;
        case (req_word.cmd)
            bole_pkg::CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    upd_status = bole_pkg::ST_FULL;
                end
                else
                begin
                    do_insert = 1'b1;
                    ins_idx   = '0;
                    upd_count = count_reg + 1'b1;
                end
            end
            bole_pkg::CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    upd_status = bole_pkg::ST_FULL;
                end
                else
                begin
                    do_insert = 1'b1;
                    ins_idx   = count_reg;
                    upd_count = count_reg + 1'b1;
                end
            end
            bole_pkg::CMD_INSERT:
            begin
                if (!pos_ok)
                begin
                    upd_status = bole_pkg::ST_BADPOS;
                end
                else if (full)
                begin
                    upd_status = bole_pkg::ST_FULL;
                end
                else
                begin
                    do_insert = 1'b1;
                    ins_idx   = CNT_W'(pos_ext - 1'b1);
                    upd_count = count_reg + 1'b1;
                end
            end
            bole_pkg::CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    upd_status = bole_pkg::ST_EMPTY;
                end
                else
                begin
                    do_pop_front = 1'b1;
                    upd_count    = count_reg - 1'b1;
                end
            end
            bole_pkg::CMD_POP_BACK:
            begin
                // back element just falls off the count
                if (empty)
                begin
                    upd_status = bole_pkg::ST_EMPTY;
                end
                else
                begin
                    upd_count = count_reg - 1'b1;
                end
            end
            bole_pkg::CMD_DUMP:
            begin
                if (empty)
                begin
                    upd_status = bole_pkg::ST_EMPTY;
                end
                else
                begin
                    start_dump = 1'b1;
                end
            end
            default:
            begin
                upd_status = bole_pkg::ST_OK;
            end
        endcase
    end

    // Next-state and result word
    always_comb
    begin
        count_next     = count_reg;
        dump_next      = dump_reg;
        dump_left_next = dump_left_reg;
        rsp_word_next  = rsp_word_reg;
        rsp_valid_next = slot_free ? 1'b0 : rsp_valid_reg;

        if (dump_adv)
        begin
            // front cell goes out, chain rotates by one
            rsp_valid_next           = 1'b1;
            rsp_word_next.status     = bole_pkg::ST_OK;
            rsp_word_next.elem_value = cell_value[0];
            rsp_word_next.count      = bole_pkg::COUNT_W'(count_reg);
            rsp_word_next.last       = (dump_left_reg == CNT_W'(1));
            dump_left_next           = dump_left_reg - 1'b1;
            if (dump_left_reg == CNT_W'(1))
            begin
                dump_next = 1'b0;
            end
        end
        else if (req_accept)
        begin
            count_next = upd_count;
            if (start_dump)
            begin
                dump_next      = 1'b1;
                dump_left_next = count_reg;
            end
            else
            begin
                rsp_valid_next           = 1'b1;
                rsp_word_next.status     = upd_status;
                rsp_word_next.elem_value = '0;
                rsp_word_next.count      = bole_pkg::COUNT_W'(upd_count);
                rsp_word_next.last       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            dump_reg      <= 1'b0;
            dump_left_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            dump_reg      <= dump_next;
            dump_left_reg <= dump_left_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // Cell chain: cell 0 is the front.
    //   insert at k: cell k loads, cells above k take from the left
    //   pop front:   every cell takes from the right
    //   dump step:   cells below count-1 take from the right, cell count-1
    //                takes the old front (rotation)
    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
        logic [bole_pkg::VAL_W-1:0] left_value;
        logic [bole_pkg::VAL_W-1:0] right_value;
        bole_pkg::cell_ctl_t        cell_ctl;

        if (i == 0)
        begin : g_first
            assign left_value = cell_value[0];
        end
        else
        begin : g_inner_l
            assign left_value = cell_value[i-1];
        end

        if (i == CAP - 1)
        begin : g_last
            assign right_value = cell_value[i];
        end
        else
        begin : g_inner_r
            assign right_value = cell_value[i+1];
        end

        always_comb
        begin
            cell_ctl.load_value = req_word.item_value;
            cell_ctl.op         = bole_pkg::CELL_HOLD;
            if (dump_adv)
            begin
                if (IDX + 1'b1 == count_reg)
                begin
                    cell_ctl.op = bole_pkg::CELL_FROM_FRONT;
                end
                else if (IDX + 1'b1 < count_reg)
                begin
                    cell_ctl.op = bole_pkg::CELL_FROM_RIGHT;
                end
            end
            else if (req_accept && do_insert)
            begin
                if (IDX == ins_idx)
                begin
                    cell_ctl.op = bole_pkg::CELL_LOAD;
                end
                else if (IDX > ins_idx)
                begin
                    cell_ctl.op = bole_pkg::CELL_FROM_LEFT;
                end
            end
            else if (req_accept && do_pop_front)
            begin
                cell_ctl.op = bole_pkg::CELL_FROM_RIGHT;
            end
        end

        bole_cell u_cell (
            .clk         (clk),
            .ctl         (cell_ctl),
            .left_value  (left_value),
            .right_value (right_value),
            .front_value (cell_value[0]),
            .value       (cell_value[i])
        );
    end

    // Checks
    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(CAP), "count over capacity")
    `ASSERT_ALWAYS(a_dump_blocks_req, clk, rst_n, !dump_reg || req_stall, "req taken during dump")
    `ASSERT_ALWAYS(a_dump_left_ok, clk, rst_n, !dump_reg || ((dump_left_reg != '0) && (dump_left_reg <= count_reg)), "dump counter out of range")
    `ASSERT_NEXT(a_dump_ends, clk, rst_n, dump_adv && (dump_left_reg == CNT_W'(1)), !dump_reg && rsp_valid && rsp_word.last, "dump did not end with last")
    `ASSERT_NEXT(a_insert_grows, clk, rst_n, req_accept && do_insert, count_reg == $past(count_reg) + 1'b1, "insert did not grow count")

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking bench for bounded_ordered_list_engine: command words in, status/dump words out.
// Depends on bole_pkg and the engine RTL; predicts results with a queue-based list model.
`timescale 1ns / 1ps

module tb_top;

    import bole_pkg::*;

    // Commands 6 and 7 are not decoded; the engine answers with a plain ok word.
    localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    localparam int RANDOM_WORDS  = 220;
    localparam int HOLD_AT_WORD  = 60;   // receiver hold-off starts here
    localparam int HOLD_CYCLES   = 48;
    localparam int STEADY_FIRST  = 100;  // no idling on either side in this window
    localparam int STEADY_LAST   = 170;
    localparam int QUIET_LIMIT   = 1000; // cycles with no handshake at all
    localparam int DRAIN_CYCLES  = 20;   // margin after the last expected result
    localparam int PRINT_CAP     = 50;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_word_t req_word  = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp_word;

    // Stimulus backlog, filled once at time zero and drained by the driver.
    req_word_t cmd_backlog[$];
    int        backlog_count = 0;   // element count as the stimulus generator sees it

    // Predictor state and the results it still expects.
    logic signed [VAL_W-1:0] shadow_list[$];
    rsp_word_t               pending_results[$];

    int words_sent     = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    bit steady_phase;

    assign steady_phase = (words_sent >= STEADY_FIRST) && (words_sent < STEADY_LAST);

    bounded_ordered_list_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Element count after a command; used only to steer the generator
    // toward valid insert positions and a sensible fill level.
    function automatic int count_after(input req_word_t w, input int c);
        case (w.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
                return (c < CAPACITY) ? c + 1 : c;
            CMD_INSERT:
                return (w.position >= 1 && int'(w.position) <= c + 1 && c < CAPACITY)
                       ? c + 1 : c;
            CMD_POP_FRONT, CMD_POP_BACK:
                return (c > 0) ? c - 1 : c;
            default:
                return c;
        endcase
    endfunction

    // Mostly random 32-bit data, with the extremes mixed in now and then.
    function automatic logic signed [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 7) != 0)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    task automatic queue_word(input logic [CMD_W-1:0] cmd, input int pos,
                              input logic signed [VAL_W-1:0] val);
        req_word_t w;
        w.cmd        = cmd;
        w.position   = pos[POS_W-1:0];
        w.item_value = val;
        cmd_backlog.push_back(w);
        backlog_count = count_after(w, backlog_count);
    endtask

    // ------------------------------------------------------------------
    // Predictor: a plain queue stands in for the cell chain, front first.
    // ------------------------------------------------------------------
    task automatic list_apply(input req_word_t w);
        rsp_word_t r;
        int        n;
        r      = '0;
        r.last = 1'b1;
        n      = shadow_list.size();
        case (w.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
                if (n >= CAPACITY)
                    r.status = ST_FULL;
                else if (w.cmd == CMD_PUSH_FRONT)
                    shadow_list.push_front(w.item_value);
                else
                    shadow_list.push_back(w.item_value);
            CMD_INSERT:
                // position range is checked before fullness
                if (w.position < 1 || int'(w.position) > n + 1)
                    r.status = ST_BADPOS;
                else if (n >= CAPACITY)
                    r.status = ST_FULL;
                else
                    shadow_list.insert(int'(w.position) - 1, w.item_value);
            CMD_POP_FRONT:
                if (n == 0)
                    r.status = ST_EMPTY;
                else
                    void'(shadow_list.pop_front());
            CMD_POP_BACK:
                if (n == 0)
                    r.status = ST_EMPTY;
                else
                    void'(shadow_list.pop_back());
            CMD_DUMP:
                if (n == 0)
                    r.status = ST_EMPTY;  // empty dump: one word, count 0
                else
                begin
                    // one word per element, last flag on the back element
                    for (int i = 0; i < n; i++)
                    begin
                        r.status     = ST_OK;
                        r.elem_value = shadow_list[i];
                        r.count      = n[COUNT_W-1:0];
                        r.last       = (i == n - 1);
                        pending_results.push_back(r);
                    end
                    return;
                end
            default:
                ;  // unused command: no change, ok status
        endcase
        r.count = COUNT_W'(shadow_list.size());
        pending_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input longint want,
                                   input longint got);
        if (mismatch_count < PRINT_CAP)
            $display("%0t mismatch: %s expected %0d got %0d", $time, what, want, got);
        mismatch_count++;
    endtask

    task automatic check_result(input rsp_word_t got);
        rsp_word_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("unexpected result word, status", 0, got.status);
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", want.status, got.status);
        if (got.elem_value !== want.elem_value)
            report_mismatch("elem_value", want.elem_value, got.elem_value);
        if (got.count !== want.count)
            report_mismatch("count", want.count, got.count);
        if (got.last !== want.last)
            report_mismatch("last", want.last, got.last);
    endtask

    // ------------------------------------------------------------------
    // Driver: a word stays on the bus until accepted; a fresh word (or an
    // idle cycle) is chosen only once the bus slot is free.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_word  <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
                words_sent <= words_sent + 1;
            if (!req_valid || !req_stall)
            begin
                if (cmd_backlog.size() != 0 &&
                    (steady_phase || $urandom_range(0, 99) >= 31))
                begin
                    req_valid <= 1'b1;
                    req_word  <= cmd_backlog.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: random back-pressure, one long hold-off so the engine
    // backs up into its input, and a quiet window with no stall at all.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (!hold_done && words_sent >= HOLD_AT_WORD)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= !steady_phase && ($urandom_range(0, 99) < 31);
    end

    // ------------------------------------------------------------------
    // Monitor: values sampled at the edge are the pre-edge ones, so an
    // accepted word here is exactly what the engine took.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                list_apply(req_word);
            if (rsp_valid && !rsp_stall)
                check_result(rsp_word);
        end
    end

    // Watchdog on handshake activity; a missing result ends up here.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL bounded_ordered_list_engine");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of test
    // ------------------------------------------------------------------
    initial
    begin
        int       r;
        bit       grow;
        bit [1:0] pick;

        // Directed: empty-list corners first.
        queue_word(CMD_DUMP,      0, '0);        // empty dump
        queue_word(CMD_POP_FRONT, 0, '0);        // pop on empty
        queue_word(CMD_POP_BACK,  0, '0);
        queue_word(CMD_INSERT,    0, 32'sd1);    // position zero is invalid
        queue_word(CMD_INSERT,    1, -32'sd1);   // insert into empty list
        queue_word(CMD_PUSH_FRONT, 0, VAL_MIN);
        queue_word(CMD_PUSH_BACK,  0, VAL_MAX);
        queue_word(CMD_INSERT, backlog_count + 1, '0);    // insert at the very back
        queue_word(CMD_INSERT, 2, 32'sh5A5A_5A5A);        // insert in the middle
        queue_word(CMD_RSVD_A, 31, '1);
        queue_word(CMD_RSVD_B, 0, '0);
        // Fill to capacity from both ends.
        while (backlog_count < CAPACITY)
            queue_word(backlog_count[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, 0, $urandom);
        queue_word(CMD_PUSH_BACK, 0, 32'sd7);    // full
        queue_word(CMD_INSERT, 17, 32'sd7);      // valid position but full
        queue_word(CMD_INSERT, 18, 32'sd7);      // bad position wins over full
        queue_word(CMD_DUMP, 0, '0);             // longest dump
        queue_word(CMD_POP_FRONT, 0, '0);
        queue_word(CMD_POP_BACK,  0, '0);

        // Random: mostly legal traffic that wanders between empty and full,
        // with some dumps and a share of raw noise words.
        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                queue_word(CMD_W'($urandom_range(0, 7)), $urandom_range(0, 31), $urandom);
            else if (r < 20)
                queue_word(CMD_DUMP, $urandom_range(0, 31), $urandom);
            else
            begin
                grow = ($urandom_range(0, CAPACITY) >= backlog_count);
                pick = 2'($urandom_range(0, 2));
                if (grow && pick == 0)
                    queue_word(CMD_PUSH_FRONT, $urandom_range(0, 31), pick_value());
                else if (grow && pick == 1)
                    queue_word(CMD_PUSH_BACK, $urandom_range(0, 31), pick_value());
                else if (grow)
                    queue_word(CMD_INSERT, $urandom_range(1, backlog_count + 1),
                               pick_value());
                else
                    queue_word(pick[0] ? CMD_POP_FRONT : CMD_POP_BACK,
                               $urandom_range(0, 31), $urandom);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || req_valid)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS bounded_ordered_list_engine");
        else
            $display("FAIL bounded_ordered_list_engine");
        $finish;
    end

endmodule
